FILE: sv/datc_pkg.sv
// Package with shared constants and the stage type of the binary64 tolerance compare.
package datc_pkg;

    localparam int unsigned ExpW  = 11;
    localparam int unsigned FracW = 52;
    localparam int unsigned WordW = 64;
    localparam logic [ExpW-1:0] ExpMax = '1;

    // Word handed from the subtractor front end to the rounding stage.
    typedef struct packed {
        logic            valid;
        logic            special;
        logic            special_eq;
        logic [ExpW-1:0] exp;
        logic [56:0]     mag;
        logic            mag_zero;
    } diff_t;

endpackage

FILE: sv/datc_tol.sv
// Tolerance limit: rounded binary64 product of 1.125 and the tolerance.
module datc_tol (
    input  logic                     clk,
    input  logic [datc_pkg::WordW-1:0] tolerance_bits,
    output logic [datc_pkg::WordW-1:0] limit_bits
);
    import datc_pkg::*;

    logic             sgn;
    logic [ExpW-1:0]  e;
    logic [FracW-1:0] f;
    logic [56:0]      sig;
    logic [56:0]      prod;
    logic [5:0]       lz;
    logic [12:0]      ex;
    logic [56:0]      nrm;
    logic [53:0]      rnd;
    logic             lsb;
    logic             rbit;
    logic             sticky;
    logic [12:0]      eo;
    logic [WordW-1:0] limit_next;
    logic [WordW-1:0] limit_reg;

    assign sgn = tolerance_bits[63];
    assign e   = tolerance_bits[62:52];
    assign f   = tolerance_bits[51:0];

    // Significand times 9/8, three extra fraction bits keep it exact.
    always_comb
    begin
        sig  = {1'b0, (e != '0), f, 3'b000};
        prod = sig + {3'b000, sig[56:3]};
        lz   = '0;
        for (int i = 0; i < 57; i++)
        begin
            if (prod[i])
            begin
                lz = 6'(56 - i);
            end
        end
        ex = (e == '0) ? 13'd1 : {2'b00, e};
        ex = ex + 13'd1;
        if (e == '0)
        begin
            // Subnormal input stays unnormalized unless it crosses into normal range.
            nrm = prod;
            if (prod[56] || prod[55])
            begin
                nrm = prod;
            end
            ex = prod[56] ? 13'd2 : 13'd1;
            nrm = prod[56] ? prod : {prod[55:0], 1'b0};
        end
        else
        begin
            nrm = prod[56] ? prod : {prod[55:0], 1'b0};
            ex  = prod[56] ? ex : ex - 13'd1;
        end
        lsb    = nrm[4];
        rbit   = nrm[3];
        sticky = |nrm[2:0];
        rnd    = {1'b0, nrm[56:4]} + 54'((rbit && (sticky || lsb)) ? 1 : 0);
        eo     = ex;
        if (rnd[53])
        begin
            eo = eo + 13'd1;
        end
        if (e == ExpMax)
        begin
            limit_next = tolerance_bits;
        end
        else if (eo >= 13'd2047)
        begin
            limit_next = {sgn, ExpMax, {FracW{1'b0}}};
        end
        else if (!rnd[53] && !rnd[52])
        begin
            limit_next = {sgn, {ExpW{1'b0}}, rnd[51:0]};
        end
        else
        begin
            limit_next = {sgn, eo[10:0], rnd[53] ? rnd[52:1] : rnd[51:0]};
        end
        if (lz == 6'd63)
        begin
            limit_next = tolerance_bits;
        end
    end

    // Register the limit once; config is to change only while idle, which the block does not enforce.
    always_ff @(posedge clk)
    begin
        limit_reg <= limit_next;
    end

    assign limit_bits = limit_reg;

endmodule

FILE: sv/datc_sub.sv
// Front end: classification, alignment and magnitude subtraction or addition.
module datc_sub (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [datc_pkg::WordW-1:0] a,
    input  logic [datc_pkg::WordW-1:0] b,
    output datc_pkg::diff_t            diff
);
    import datc_pkg::*;

    typedef struct packed {
        logic            valid;
        logic            special;
        logic            special_eq;
        logic            sub;
        logic [ExpW-1:0] exp;
        logic [55:0]     big;
        logic [55:0]     sml;
    } align_t;

    logic   na, nb, ia, ib;
    logic   a_big;
    logic [ExpW-1:0] ea, eb, ebig, esml;
    logic [52:0] ma, mb, mbig, msml;
    logic [11:0] sh;
    logic [108:0] wide;
    align_t align_next, align_reg;
    diff_t  diff_next, diff_reg;

    // Classify, order by magnitude, align the smaller with sticky.
    always_comb
    begin
        ea = a[62:52];
        eb = b[62:52];
        na = (ea == ExpMax) && (a[51:0] != '0);
        nb = (eb == ExpMax) && (b[51:0] != '0);
        ia = (ea == ExpMax) && (a[51:0] == '0);
        ib = (eb == ExpMax) && (b[51:0] == '0);
        ma = {(ea != '0), a[51:0]};
        mb = {(eb != '0), b[51:0]};
        a_big = (a[62:0] >= b[62:0]);
        ebig = a_big ? ((ea == '0) ? 11'd1 : ea) : ((eb == '0) ? 11'd1 : eb);
        esml = a_big ? ((eb == '0) ? 11'd1 : eb) : ((ea == '0) ? 11'd1 : ea);
        mbig = a_big ? ma : mb;
        msml = a_big ? mb : ma;
        sh   = {1'b0, ebig} - {1'b0, esml};
        wide = {msml, 56'd0};
        if (sh < 12'd60)
        begin
            wide = wide >> sh;
        end
        else
        begin
            wide = {55'd0, 54'((msml != '0) ? 1 : 0)};
        end
        align_next.valid      = in_valid;
        align_next.special    = na || nb || ia || ib;
        align_next.special_eq = (na && nb) || (!na && !nb && ia && ib && (a[63] == b[63]));
        align_next.sub        = a[63] == b[63];
        align_next.exp        = ebig;
        align_next.big        = {mbig, 3'b000};
        align_next.sml        = {wide[108:56], wide[55:54], |wide[53:0]};
    end

    // Add or subtract the aligned magnitudes.
    always_comb
    begin
        diff_next.valid      = align_reg.valid;
        diff_next.special    = align_reg.special;
        diff_next.special_eq = align_reg.special_eq;
        diff_next.exp        = align_reg.exp;
        if (align_reg.sub)
        begin
            diff_next.mag = {1'b0, align_reg.big} - {1'b0, align_reg.sml};
        end
        else
        begin
            diff_next.mag = {1'b0, align_reg.big} + {1'b0, align_reg.sml};
        end
        diff_next.mag_zero = (diff_next.mag == '0);
    end

    // Stage registers; the whole word clears on reset so valid starts low.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= '0;
            diff_reg  <= '0;
        end
        else
        begin
            align_reg <= align_next;
            diff_reg  <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

FILE: sv/datc_cmp.sv
// Back end: normalize and round the magnitude, then compare with the limit.
module datc_cmp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  datc_pkg::diff_t            diff,
    input  logic [datc_pkg::WordW-1:0] limit_bits,
    output logic                       done,
    output logic                       values_equal
);
    import datc_pkg::*;

    typedef struct packed {
        logic            valid;
        logic            special;
        logic            special_eq;
        logic            zero;
        logic [62:0]     mag;
        logic            ovf;
    } rnd_t;

    logic [5:0]  lz;
    logic [12:0] ex;
    logic [56:0] nrm;
    logic [53:0] r;
    logic [12:0] eo;
    rnd_t rnd_next, rnd_reg;
    logic done_next, done_reg;
    logic eq_next, eq_reg;
    logic lim_nan, lim_neg;

    // Leading-zero normalize, clamped at the subnormal boundary, then round.
    always_comb
    begin
        lz = 6'd57;
        for (int i = 0; i < 57; i++)
        begin
            if (diff.mag[i])
            begin
                lz = 6'(56 - i);
            end
        end
        ex  = {2'b00, diff.exp} + 13'd1;
        nrm = diff.mag;
        if (diff.mag[56])
        begin
            nrm = diff.mag;
        end
        else
        begin
            if ({7'd0, lz} < ex)
            begin
                nrm = diff.mag << lz;
                ex  = ex - {7'd0, lz};
            end
            else
            begin
                nrm = diff.mag << 6'(ex - 13'd1);
                ex  = 13'd1;
            end
        end
        r  = {1'b0, nrm[56:4]} + 54'((nrm[3] && ((|nrm[2:0]) || nrm[4])) ? 1 : 0);
        // The bit at position 56 of nrm carries the biased exponent ex.
        eo = ex;
        if (r[53])
        begin
            eo = eo + 13'd1;
        end
        rnd_next.valid      = diff.valid;
        rnd_next.special    = diff.special;
        rnd_next.special_eq = diff.special_eq;
        rnd_next.zero       = diff.mag_zero;
        rnd_next.ovf        = eo >= 13'd2047;
        if (!r[53] && !r[52])
        begin
            rnd_next.mag = {11'd0, r[51:0]};
        end
        else
        begin
            rnd_next.mag = {eo[10:0], r[53] ? r[52:1] : r[51:0]};
        end
    end

    // Compare the magnitude with the limit; a negative limit passes only a zero
    // difference against negative zero.
    always_comb
    begin
        lim_nan = (limit_bits[62:52] == ExpMax) && (limit_bits[51:0] != '0);
        lim_neg = limit_bits[63];
        done_next = rnd_reg.valid;
        if (rnd_reg.special)
        begin
            eq_next = rnd_reg.special_eq;
        end
        else if (rnd_reg.ovf || lim_nan)
        begin
            eq_next = 1'b0;
        end
        else if (lim_neg)
        begin
            eq_next = rnd_reg.zero && (limit_bits[62:0] == '0);
        end
        else
        begin
            eq_next = rnd_reg.zero || (rnd_reg.mag <= limit_bits[62:0]);
        end
    end

    // Stage register and result strobe, cleared on reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eq_reg <= eq_next;
    end

    assign done         = done_reg;
    assign values_equal = eq_reg;

    // A result strobe always follows a valid word held in the rounding stage register.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rnd_reg.valid |=> done_reg) else $error("lost result word");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !rnd_reg.valid |=> !done_reg) else $error("spurious result word");
    a_special_eq: assert property (@(posedge clk) disable iff (!rst_n)
        (rnd_reg.valid && rnd_reg.special) |=> (values_equal == $past(rnd_reg.special_eq)))
        else $error("special case result wrong");

endmodule

FILE: sv/double_abs_tolerance_compare.sv
// Top level of the binary64 absolute tolerance compare.
// A word (first_value, second_value) is taken on any cycle with start high; busy is
// never raised, so one word enters every cycle. Each result appears on values_equal
// with done high for one cycle, after the four register stages of align, subtract,
// normalize-round and compare. The receiver cannot stall.
// A cfg_we write sets the tolerance register, from which the limit is registered in turn.
module double_abs_tolerance_compare (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [datc_pkg::WordW-1:0] first_value,
    input  logic [datc_pkg::WordW-1:0] second_value,
    input  logic                       cfg_we,
    input  logic [datc_pkg::WordW-1:0] cfg_wdata,
    output logic                       done,
    output logic                       values_equal
);
    import datc_pkg::*;

    logic [WordW-1:0] tol_reg;
    logic [WordW-1:0] tol_next;
    logic [WordW-1:0] limit_bits;
    diff_t            diff;

    // Tolerance register.
    assign tol_next = cfg_we ? cfg_wdata : tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else
        begin
            tol_reg <= tol_next;
        end
    end

    assign busy = 1'b0;

    datc_tol u_tol (
        .clk            (clk),
        .tolerance_bits (tol_reg),
        .limit_bits     (limit_bits)
    );

    datc_sub u_sub (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .a        (first_value),
        .b        (second_value),
        .diff     (diff)
    );

    datc_cmp u_cmp (
        .clk          (clk),
        .rst_n        (rst_n),
        .diff         (diff),
        .limit_bits   (limit_bits),
        .done         (done),
        .values_equal (values_equal)
    );

endmodule
